// File: design/gdcs_pkg.sv
// Shared types and constants for the GPS duty-cycle sequencer.
// No dependencies; every other design file refers to this package by scoped names.
`timescale 1ns / 1ps

package gdcs_pkg;

    localparam int REQ_W  = 3;
    localparam int TIME_W = 32;
    localparam int SAT_W  = 8;
    localparam int CFG_W  = 32;
    localparam int ADDR_W = 5;

    // Request codes carried in req_type.
    localparam logic [REQ_W-1:0] REQ_TICK        = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOW_WAKE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INHIBIT     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEEP_SLEEP  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SAT_COUNT   = 3'd4;

    // Register indexes; register i sits at byte address 4*i.
    localparam logic [2:0] REG_ATTEMPT_TIME    = 3'd0;
    localparam logic [2:0] REG_UPDATE_INTERVAL = 3'd1;
    localparam logic [2:0] REG_ROUTER_ROLE     = 3'd2;
    localparam logic [2:0] REG_GPS_DISABLED    = 3'd3;
    localparam logic [2:0] REG_SHARE_DISABLED  = 3'd4;

    localparam logic [TIME_W-1:0] FOREVER_MS       = 32'hFFFF_FFFF;
    localparam logic [TIME_W-1:0] ACTIVE_PERIOD_MS = 32'd5000;
    localparam logic [9:0]        MS_PER_S         = 10'd1000;

    localparam logic [TIME_W-1:0] ROUTER_ATTEMPT_S  = 32'd300;    // 5 * 60
    localparam logic [TIME_W-1:0] DEFAULT_ATTEMPT_S = 32'd900;    // 15 * 60
    localparam logic [TIME_W-1:0] ROUTER_UPDATE_S   = 32'd86400;  // 24 * 60 * 60
    localparam logic [TIME_W-1:0] DEFAULT_UPDATE_S  = 32'd120;    // 2 * 60

    // Intervals derived from the configuration, in milliseconds.
    typedef struct packed {
        logic [TIME_W-1:0] attempt_ms;
        logic [TIME_W-1:0] interval_ms;
    } cfg_t;

    // One request as held in the input register.
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [TIME_W-1:0] now_ms;
        logic              nmea_seen;
        logic              time_found;
        logic              rtc_has_gps_time;
        logic              location_found;
        logic [SAT_W-1:0]  satellite_count;
    } req_item_t;

endpackage

// File: design/gdcs_ifs.sv
// Valid/ready channel interfaces for requests and results of the sequencer.
// Depends on gdcs_pkg for field widths.
`timescale 1ns / 1ps

interface gdcs_req_if;
    logic                         valid;
    logic                         ready;
    logic [gdcs_pkg::REQ_W-1:0]   req_type;
    logic [gdcs_pkg::TIME_W-1:0]  now_ms;
    logic                         nmea_seen;
    logic                         time_found;
    logic                         rtc_has_gps_time;
    logic                         location_found;
    logic [gdcs_pkg::SAT_W-1:0]   satellite_count;

    modport source (
        output valid, req_type, now_ms, nmea_seen, time_found,
               rtc_has_gps_time, location_found, satellite_count,
        input  ready
    );
    modport sink (
        input  valid, req_type, now_ms, nmea_seen, time_found,
               rtc_has_gps_time, location_found, satellite_count,
        output ready
    );
endinterface

interface gdcs_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        gps_awake;
    logic                        location_valid;
    logic                        receiver_connected;
    logic                        publish_status;
    logic                        run_active_work;
    logic                        clear_position;
    logic                        slow_poll;
    logic [gdcs_pkg::SAT_W-1:0]  satellites;

    modport source (
        output valid, gps_awake, location_valid, receiver_connected, publish_status,
               run_active_work, clear_position, slow_poll, satellites,
        input  ready
    );
    modport sink (
        input  valid, gps_awake, location_valid, receiver_connected, publish_status,
               run_active_work, clear_position, slow_poll, satellites,
        output ready
    );
endinterface

// File: design/gdcs_regs.sv
// APB configuration registers and the millisecond intervals derived from them.
// Depends on gdcs_pkg.
`timescale 1ns / 1ps

module gdcs_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gdcs_pkg::ADDR_W-1:0]   paddr,
    input  logic [gdcs_pkg::CFG_W-1:0]    pwdata,
    output logic [gdcs_pkg::CFG_W-1:0]    prdata,
    output logic                          pready,
    output gdcs_pkg::cfg_t                cfg
);

    logic [31:0] attempt_s_reg;
    logic [31:0] update_s_reg;
    logic        router_reg;
    logic        gps_dis_reg;
    logic        share_dis_reg;

    logic [2:0]  reg_idx;
    logic        wr_en;

    logic [31:0] attempt_eff;
    logic [31:0] update_eff;
    logic [41:0] attempt_prod;
    logic [41:0] update_prod;
    gdcs_pkg::cfg_t cfg_next;
    gdcs_pkg::cfg_t cfg_reg;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attempt_s_reg <= '0;
            update_s_reg  <= '0;
            router_reg    <= 1'b0;
            gps_dis_reg   <= 1'b0;
            share_dis_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                gdcs_pkg::REG_ATTEMPT_TIME:    attempt_s_reg <= pwdata;
                gdcs_pkg::REG_UPDATE_INTERVAL: update_s_reg  <= pwdata;
                gdcs_pkg::REG_ROUTER_ROLE:     router_reg    <= pwdata[0];
                gdcs_pkg::REG_GPS_DISABLED:    gps_dis_reg   <= pwdata[0];
                gdcs_pkg::REG_SHARE_DISABLED:  share_dis_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            gdcs_pkg::REG_ATTEMPT_TIME:    prdata = attempt_s_reg;
            gdcs_pkg::REG_UPDATE_INTERVAL: prdata = update_s_reg;
            gdcs_pkg::REG_ROUTER_ROLE:     prdata = {31'd0, router_reg};
            gdcs_pkg::REG_GPS_DISABLED:    prdata = {31'd0, gps_dis_reg};
            gdcs_pkg::REG_SHARE_DISABLED:  prdata = {31'd0, share_dis_reg};
            default:                       prdata = '0;
        endcase
    end

    // A zero setting picks the role default; the product saturates to forever.
    always_comb
    begin
        if (attempt_s_reg == '0)
            attempt_eff = router_reg ? gdcs_pkg::ROUTER_ATTEMPT_S : gdcs_pkg::DEFAULT_ATTEMPT_S;
        else
            attempt_eff = attempt_s_reg;

        if (update_s_reg == '0)
            update_eff = router_reg ? gdcs_pkg::ROUTER_UPDATE_S : gdcs_pkg::DEFAULT_UPDATE_S;
        else
            update_eff = update_s_reg;

        attempt_prod = {10'd0, attempt_eff} * {32'd0, gdcs_pkg::MS_PER_S};
        update_prod  = {10'd0, update_eff} * {32'd0, gdcs_pkg::MS_PER_S};

        if (attempt_s_reg == gdcs_pkg::FOREVER_MS || attempt_prod[41:32] != '0)
            cfg_next.attempt_ms = gdcs_pkg::FOREVER_MS;
        else
            cfg_next.attempt_ms = attempt_prod[31:0];

        if (gps_dis_reg || share_dis_reg || update_s_reg == gdcs_pkg::FOREVER_MS
            || update_prod[41:32] != '0)
            cfg_next.interval_ms = gdcs_pkg::FOREVER_MS;
        else
            cfg_next.interval_ms = update_prod[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attempt_ms  <= 32'd900000;
            cfg_reg.interval_ms <= 32'd120000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/gps_duty_cycle_sequencer.sv
// Top level of the GPS duty-cycle sequencer: request pipeline and power state.
// Depends on gdcs_pkg, the channel interfaces in gdcs_ifs.sv and gdcs_regs.
`timescale 1ns / 1ps

// The sequencer decides when a GPS receiver is powered. Requests arrive on the
// req channel: a tick with the current millisecond time and the receiver's
// findings, or an event (allow wake, inhibit wake, deep sleep, satellite count).
// Each request yields exactly one result on the rsp channel with the power
// state, location and connection status, and the pulses for this request.
// A request is taken into an input register; once the result register is free or
// being drained, the state update and the result are computed in one pass and
// loaded into the result register. The block sustains one request per cycle
// while rsp.ready stays high. The result register and the input register
// decouple the channels: with a result waiting, one more request is still
// accepted, and req.ready drops only while both registers are full.
// The APB port holds the interval settings; the millisecond intervals are
// registered from them in the cycle after each write.
// After reset the receiver is asleep, wake is allowed, no location is held,
// the sleep interval is measured from time zero and both channels are empty.

module gps_duty_cycle_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    gdcs_req_if.sink                      req,
    gdcs_rsp_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gdcs_pkg::ADDR_W-1:0]   paddr,
    input  logic [gdcs_pkg::CFG_W-1:0]    pwdata,
    output logic [gdcs_pkg::CFG_W-1:0]    prdata,
    output logic                          pready
);

    gdcs_pkg::cfg_t cfg;

    gdcs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register.
    logic                 s1_valid_reg;
    gdcs_pkg::req_item_t  s1_reg;
    logic                 adv;

    // Result register.
    logic                 o_valid_reg;
    logic                 o_valid_next;

    // Sequencer state.
    logic        awake_reg,       awake_next;
    logic        allowed_reg,     allowed_next;
    logic        held_reg,        held_next;
    logic        conn_reg,        conn_next;
    logic        pend_reg,        pend_next;
    logic [7:0]  sat_reg,         sat_next;
    logic [31:0] wake_start_reg,  wake_start_next;
    logic [31:0] sleep_start_reg, sleep_start_next;
    logic [31:0] active_run_reg,  active_run_next;

    logic        pub, work, clr;
    logic        wake_due, aw, got_time, too_long;
    logic [31:0] sleep_el, wake_el, run_el, ws_eff;

    // The input register advances when the result register is free or drained.
    assign adv       = s1_valid_reg && (!o_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || adv;

    assign o_valid_next = adv ? 1'b1 : (o_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= (req.valid && req.ready) ? 1'b1 : (s1_valid_reg && !adv);
            o_valid_reg  <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_reg.req_type         <= req.req_type;
            s1_reg.now_ms           <= req.now_ms;
            s1_reg.nmea_seen        <= req.nmea_seen;
            s1_reg.time_found       <= req.time_found;
            s1_reg.rtc_has_gps_time <= req.rtc_has_gps_time;
            s1_reg.location_found   <= req.location_found;
            s1_reg.satellite_count  <= req.satellite_count;
        end
    end

    // Elapsed times are wrapping differences. A wake on this tick restarts the
    // attempt at the current time, so it cannot time out on the same tick.
    assign sleep_el = s1_reg.now_ms - sleep_start_reg;
    assign run_el   = s1_reg.now_ms - active_run_reg;
    assign wake_due = !awake_reg && allowed_reg && (cfg.interval_ms != gdcs_pkg::FOREVER_MS)
                      && (sleep_el > cfg.interval_ms);
    assign aw       = awake_reg || wake_due;
    assign ws_eff   = wake_due ? s1_reg.now_ms : wake_start_reg;
    assign wake_el  = s1_reg.now_ms - ws_eff;
    assign got_time = s1_reg.rtc_has_gps_time || s1_reg.time_found;
    assign too_long = (cfg.attempt_ms != gdcs_pkg::FOREVER_MS) && (wake_el > cfg.attempt_ms);

    always_comb
    begin
        awake_next       = awake_reg;
        allowed_next     = allowed_reg;
        held_next        = held_reg;
        conn_next        = conn_reg;
        pend_next        = pend_reg;
        sat_next         = sat_reg;
        wake_start_next  = wake_start_reg;
        sleep_start_next = sleep_start_reg;
        active_run_next  = active_run_reg;
        pub  = 1'b0;
        work = 1'b0;
        clr  = 1'b0;

        case (s1_reg.req_type)
            gdcs_pkg::REQ_TICK:
            begin
                if (s1_reg.nmea_seen && !conn_reg)
                begin
                    conn_next = 1'b1;
                    pend_next = 1'b1;
                end
                if (wake_due)
                begin
                    awake_next      = 1'b1;
                    wake_start_next = s1_reg.now_ms;
                end
                if (aw)
                begin
                    if (run_el > gdcs_pkg::ACTIVE_PERIOD_MS)
                    begin
                        active_run_next = s1_reg.now_ms;
                        work            = 1'b1;
                    end
                    if (!s1_reg.rtc_has_gps_time && s1_reg.time_found)
                        pend_next = 1'b1;
                    if (s1_reg.location_found && !held_reg)
                    begin
                        held_next = 1'b1;
                        pend_next = 1'b1;
                    end
                    if ((s1_reg.location_found && got_time) || too_long)
                    begin
                        if (too_long)
                        begin
                            clr       = 1'b1;
                            held_next = 1'b0;
                        end
                        awake_next       = 1'b0;
                        sleep_start_next = s1_reg.now_ms;
                        pend_next        = 1'b1;
                    end
                end
                pub       = pend_next;
                pend_next = 1'b0;
            end
            gdcs_pkg::REQ_ALLOW_WAKE: allowed_next = 1'b1;
            gdcs_pkg::REQ_INHIBIT:    allowed_next = 1'b0;
            gdcs_pkg::REQ_DEEP_SLEEP:
            begin
                if (awake_reg)
                begin
                    awake_next       = 1'b0;
                    sleep_start_next = s1_reg.now_ms;
                end
            end
            gdcs_pkg::REQ_SAT_COUNT:
            begin
                if (s1_reg.satellite_count != sat_reg)
                begin
                    sat_next  = s1_reg.satellite_count;
                    pend_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awake_reg       <= 1'b0;
            allowed_reg     <= 1'b1;
            held_reg        <= 1'b0;
            conn_reg        <= 1'b0;
            pend_reg        <= 1'b0;
            sat_reg         <= '0;
            wake_start_reg  <= '0;
            sleep_start_reg <= '0;
            active_run_reg  <= '0;
        end
        else if (adv)
        begin
            awake_reg       <= awake_next;
            allowed_reg     <= allowed_next;
            held_reg        <= held_next;
            conn_reg        <= conn_next;
            pend_reg        <= pend_next;
            sat_reg         <= sat_next;
            wake_start_reg  <= wake_start_next;
            sleep_start_reg <= sleep_start_next;
            active_run_reg  <= active_run_next;
        end
    end

    // Result payload, loaded with the state as it stands after the request.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp.gps_awake          <= awake_next;
            rsp.location_valid     <= held_next;
            rsp.receiver_connected <= conn_next;
            rsp.publish_status     <= pub;
            rsp.run_active_work    <= work;
            rsp.clear_position     <= clr;
            rsp.slow_poll          <= !awake_next;
            rsp.satellites         <= sat_next;
        end
    end

    assign rsp.valid = o_valid_reg;

`ifndef ASSERT_OFF
    // A timed-out attempt always ends asleep and without a location.
    a_clear_sleeps: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.clear_position |-> !rsp.gps_awake && !rsp.location_valid)
        else $error("clear_position with receiver awake or location held");

    // The poll rate follows the power state of the same result.
    a_poll_matches: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.slow_poll == !rsp.gps_awake)
        else $error("slow_poll does not match gps_awake");

    // A processed deep sleep leaves the receiver asleep.
    a_deep_sleep: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s1_reg.req_type == gdcs_pkg::REQ_DEEP_SLEEP |=> !awake_reg)
        else $error("receiver awake after deep sleep");

    // The receiver only wakes on a processed tick.
    a_wake_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(awake_reg) |-> $past(adv && s1_reg.req_type == gdcs_pkg::REQ_TICK))
        else $error("receiver woke outside a tick");

    // Once the receiver has been seen it stays connected.
    a_conn_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        conn_reg |=> conn_reg)
        else $error("receiver_connected dropped");
`endif

endmodule

// File: sim/gdcs_status_checker.sv
// Status checker for the GPS duty-cycle sequencer: predicts every result from the
// accepted requests and register writes, and compares it with what the block returns.
// Depends on gdcs_pkg and the channel interfaces in design/gdcs_ifs.sv.
`timescale 1ns / 1ps

module gdcs_status_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    gdcs_req_if                           req,
    gdcs_rsp_if                           rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [gdcs_pkg::ADDR_W-1:0]   paddr,
    input  logic [gdcs_pkg::CFG_W-1:0]    pwdata,
    output int unsigned                   mismatches,
    output int unsigned                   outstanding
);
    import gdcs_pkg::*;

    typedef struct packed {
        logic             gps_awake;
        logic             location_valid;
        logic             receiver_connected;
        logic             publish_status;
        logic             run_active_work;
        logic             clear_position;
        logic             slow_poll;
        logic [SAT_W-1:0] satellites;
    } status_t;

    // Register copies.
    logic [CFG_W-1:0]  attempt_s;
    logic [CFG_W-1:0]  update_s;
    logic              router;
    logic              gps_off;
    logic              share_off;

    // Power and status state.
    logic              awake;
    logic              wake_ok;
    logic              loc_held;
    logic              connected;
    logic              pub_pending;
    logic [SAT_W-1:0]  sats_held;
    logic [TIME_W-1:0] wake_t;
    logic [TIME_W-1:0] sleep_t;
    logic [TIME_W-1:0] work_t;

    status_t           expected_status_q[$];
    int unsigned       errors;

    // Seconds to milliseconds; anything past 32 bits means forever.
    function automatic logic [TIME_W-1:0] to_ms(input logic [CFG_W-1:0] secs);
        logic [63:0] prod;
        prod = 64'(secs) * 64'(MS_PER_S);
        return (prod > 64'(FOREVER_MS)) ? FOREVER_MS : prod[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] attempt_window_ms();
        if (attempt_s == '1)
            return FOREVER_MS;
        if (attempt_s == '0)
            return to_ms(router ? ROUTER_ATTEMPT_S : DEFAULT_ATTEMPT_S);
        return to_ms(attempt_s);
    endfunction

    function automatic logic [TIME_W-1:0] sleep_window_ms();
        if (gps_off || share_off || update_s == '1)
            return FOREVER_MS;
        if (update_s == '0)
            return to_ms(router ? ROUTER_UPDATE_S : DEFAULT_UPDATE_S);
        return to_ms(update_s);
    endfunction

    task automatic set_power(input logic on, input logic [TIME_W-1:0] at_ms);
        logic want;
        want = on && wake_ok;
        if (awake != want) begin
            if (want)
                wake_t = at_ms;
            else
                sleep_t = at_ms;
            awake = want;
        end
    endtask

    task automatic predict_status(input req_item_t it, output status_t st);
        logic              pub;
        logic              work;
        logic              clr;
        logic              got_time;
        logic              too_long;
        logic [TIME_W-1:0] window;
        pub  = 1'b0;
        work = 1'b0;
        clr  = 1'b0;
        case (it.req_type)
            REQ_TICK:
            begin
                window = sleep_window_ms();
                if (it.nmea_seen && !connected) begin
                    connected   = 1'b1;
                    pub_pending = 1'b1;
                end
                if (!awake && window != FOREVER_MS && TIME_W'(it.now_ms - sleep_t) > window)
                    set_power(1'b1, it.now_ms);
                if (awake) begin
                    got_time = it.rtc_has_gps_time;
                    if (TIME_W'(it.now_ms - work_t) > ACTIVE_PERIOD_MS) begin
                        work_t = it.now_ms;
                        work   = 1'b1;
                    end
                    if (!got_time && it.time_found) begin
                        got_time    = 1'b1;
                        pub_pending = 1'b1;
                    end
                    if (it.location_found && !loc_held) begin
                        loc_held    = 1'b1;
                        pub_pending = 1'b1;
                    end
                    window   = attempt_window_ms();
                    too_long = window != FOREVER_MS && TIME_W'(it.now_ms - wake_t) > window;
                    if ((it.location_found && got_time) || too_long) begin
                        if (too_long) begin
                            clr      = 1'b1;
                            loc_held = 1'b0;
                        end
                        set_power(1'b0, it.now_ms);
                        pub_pending = 1'b1;
                    end
                end
                pub         = pub_pending;
                pub_pending = 1'b0;
            end
            REQ_ALLOW_WAKE:
                wake_ok = 1'b1;
            REQ_INHIBIT:
                wake_ok = 1'b0;
            REQ_DEEP_SLEEP:
                set_power(1'b0, it.now_ms);
            REQ_SAT_COUNT:
            begin
                if (it.satellite_count != sats_held) begin
                    sats_held   = it.satellite_count;
                    pub_pending = 1'b1;
                end
            end
            default:
                ;
        endcase
        st = '{awake, loc_held, connected, pub, work, clr, !awake, sats_held};
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        req_item_t item;
        status_t   want;
        status_t   got;
        if (!rst_n) begin
            attempt_s   = '0;
            update_s    = '0;
            router      = 1'b0;
            gps_off     = 1'b0;
            share_off   = 1'b0;
            awake       = 1'b0;
            wake_ok     = 1'b1;
            loc_held    = 1'b0;
            connected   = 1'b0;
            pub_pending = 1'b0;
            sats_held   = '0;
            wake_t      = '0;
            sleep_t     = '0;
            work_t      = '0;
            errors      = 0;
            expected_status_q.delete();
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_ATTEMPT_TIME:    attempt_s = pwdata;
                    REG_UPDATE_INTERVAL: update_s  = pwdata;
                    REG_ROUTER_ROLE:     router    = pwdata[0];
                    REG_GPS_DISABLED:    gps_off   = pwdata[0];
                    REG_SHARE_DISABLED:  share_off = pwdata[0];
                    default:             ;
                endcase
            end
            if (rsp.valid && rsp.ready) begin
                got = '{rsp.gps_awake, rsp.location_valid, rsp.receiver_connected,
                        rsp.publish_status, rsp.run_active_work, rsp.clear_position,
                        rsp.slow_poll, rsp.satellites};
                if (expected_status_q.size() == 0) begin
                    $error("result returned with no request outstanding");
                    errors++;
                end
                else begin
                    want = expected_status_q.pop_front();
                    check_field("gps_awake", want.gps_awake, got.gps_awake);
                    check_field("location_valid", want.location_valid, got.location_valid);
                    check_field("receiver_connected", want.receiver_connected,
                                got.receiver_connected);
                    check_field("publish_status", want.publish_status, got.publish_status);
                    check_field("run_active_work", want.run_active_work,
                                got.run_active_work);
                    check_field("clear_position", want.clear_position, got.clear_position);
                    check_field("slow_poll", want.slow_poll, got.slow_poll);
                    check_field("satellites", want.satellites, got.satellites);
                end
            end
            if (req.valid && req.ready) begin
                item = '{req.req_type, req.now_ms, req.nmea_seen, req.time_found,
                         req.rtc_has_gps_time, req.location_found, req.satellite_count};
                predict_status(item, want);
                expected_status_q.push_back(want);
            end
        end
        mismatches  <= errors;
        outstanding <= expected_status_q.size();
    end

endmodule

// File: sim/gps_duty_cycle_sequencer_tb.sv
// Testbench top for the GPS duty-cycle sequencer: clock, reset, request stimulus,
// result back-pressure, register writes and the verdict. Depends on gdcs_pkg, the
// channel interfaces, the block itself and gdcs_status_checker.
`timescale 1ns / 1ps

module gps_duty_cycle_sequencer_tb;
    import gdcs_pkg::*;

    localparam int CLK_PERIOD_NS  = 12;
    localparam int RESET_CYCLES   = 11;
    // Cycles without any handshake or register write before the run is abandoned.
    // The slowest correct stretch is an idle burst on the request side plus a stall
    // on the result side plus the pipeline delay, so this is far beyond any legal pause.
    localparam int WATCHDOG_LIMIT = 1000;
    // Cycles allowed after the last result before the verdict.
    localparam int SETTLE_CYCLES  = 8;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic              pready;
    logic [ADDR_W-1:0] paddr;
    logic [CFG_W-1:0]  pwdata;
    logic [CFG_W-1:0]  prdata;
    int unsigned       mismatches;
    int unsigned       outstanding;

    // Running millisecond time handed to ticks and events.
    logic [TIME_W-1:0] clock_ms;
    logic [SAT_W-1:0]  last_sats;
    // Random idling on the request side and stalls on the result side.
    logic              sender_idles;
    logic              receiver_stalls;

    gdcs_req_if req();
    gdcs_rsp_if rsp();

    gps_duty_cycle_sequencer uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // The checker sees the same channels and register port as the block; it predicts
    // each result and reports how many fields disagreed and how many results are due.
    gdcs_status_checker status_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD_NS / 2) clk = ~clk;
    end

    function automatic req_item_t make_req(input logic [REQ_W-1:0] kind,
                                           input logic [TIME_W-1:0] now,
                                           input logic nmea, input logic tfound,
                                           input logic rtc_ok, input logic lfound,
                                           input logic [SAT_W-1:0] sats);
        req_item_t it;
        it = '{kind, now, nmea, tfound, rtc_ok, lfound, sats};
        return it;
    endfunction

    // Offers one request and returns at the clock edge that accepts it. With idling
    // on, a request is sometimes preceded by a random burst of empty cycles.
    task automatic send_request(input req_item_t it);
        if (sender_idles && $urandom_range(0, 5) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        req.valid            <= 1'b1;
        req.req_type         <= it.req_type;
        req.now_ms           <= it.now_ms;
        req.nmea_seen        <= it.nmea_seen;
        req.time_found       <= it.time_found;
        req.rtc_has_gps_time <= it.rtc_has_gps_time;
        req.location_found   <= it.location_found;
        req.satellite_count  <= it.satellite_count;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // Stops offering requests and waits until every predicted result has been
    // returned. The first edge lets the checker count the last accepted request.
    task automatic drain_results();
        req.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // One APB write: setup cycle, access cycle, then the bus is released. pready is
    // always high, so the register takes the value at the edge that ends the access.
    task automatic apb_write(input logic [2:0] reg_idx, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // One setting of the registers followed by random requests. Writes happen only
    // once the block is empty. Most requests are ticks so that acquisitions really
    // start and end; time mostly moves in small steps against the short windows,
    // with occasional long jumps and wraps that reach the long defaults and the top
    // bits of the time field.
    task automatic run_phase(input logic [CFG_W-1:0] attempt_s,
                             input logic [CFG_W-1:0] update_s,
                             input logic router, input logic gps_off,
                             input logic share_off, input int items, input logic calm);
        req_item_t   it;
        int unsigned pick;
        drain_results();
        repeat (2) @(posedge clk);
        apb_write(REG_ATTEMPT_TIME, attempt_s);
        apb_write(REG_UPDATE_INTERVAL, update_s);
        apb_write(REG_ROUTER_ROLE, CFG_W'(router));
        apb_write(REG_GPS_DISABLED, CFG_W'(gps_off));
        apb_write(REG_SHARE_DISABLED, CFG_W'(share_off));
        sender_idles    = !calm;
        receiver_stalls = !calm;
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick == 0)
                clock_ms = $urandom();
            else if (pick < 6)
                clock_ms = clock_ms + $urandom();
            else
                clock_ms = clock_ms + $urandom_range(0, 1200);

            it.now_ms           = clock_ms;
            it.nmea_seen        = 1'($urandom_range(0, 1));
            it.time_found       = ($urandom_range(0, 3) == 0);
            it.rtc_has_gps_time = ($urandom_range(0, 7) == 0);
            it.location_found   = ($urandom_range(0, 3) == 0);
            // Half the requests reuse the last satellite count drawn, so a report may change nothing.
            if ($urandom_range(0, 1) == 0)
                last_sats = SAT_W'($urandom_range(0, 255));
            it.satellite_count  = last_sats;

            pick = $urandom_range(0, 99);
            if (pick < 70)
                it.req_type = REQ_TICK;
            else if (pick < 78)
                it.req_type = REQ_ALLOW_WAKE;
            else if (pick < 83)
                it.req_type = REQ_INHIBIT;
            else if (pick < 88)
                it.req_type = REQ_DEEP_SLEEP;
            else if (pick < 97)
                it.req_type = REQ_SAT_COUNT;
            else
                // The codes above the satellite report are unused and must be ignored.
                it.req_type = REQ_SAT_COUNT + REQ_W'($urandom_range(1, 3));

            send_request(it);

            // Now and then the sender holds back until the block has answered everything.
            if (!calm && $urandom_range(0, 99) == 0)
                drain_results();
        end
    endtask

    // Result side: ready is held high for a while, and with stalls enabled it drops
    // now and then between those stretches.
    initial begin
        rsp.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (receiver_stalls && $urandom_range(0, 3) == 0) begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // Watchdog: any cycle with a request, a result or a register write restarts the
    // count. A hang or a result that never comes ends the run here.
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
                (psel && penable && pwrite))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL gps_duty_cycle_sequencer");
        $finish;
    end

    initial begin
        // Every input of the block is known from time zero.
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        req.valid            = 1'b0;
        req.req_type         = REQ_TICK;
        req.now_ms           = '0;
        req.nmea_seen        = 1'b0;
        req.time_found       = 1'b0;
        req.rtc_has_gps_time = 1'b0;
        req.location_found   = 1'b0;
        req.satellite_count  = '0;
        sender_idles         = 1'b1;
        receiver_stalls      = 1'b1;
        clock_ms             = '0;
        last_sats            = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests with the reset settings: 15 minute attempts and a
        // two minute sleep interval measured from time zero.
        // First sentences from the receiver mark it connected and publish that.
        send_request(make_req(REQ_TICK, 32'd0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0));
        // Satellite reports: a change, a repeat that changes nothing, the low extreme.
        send_request(make_req(REQ_SAT_COUNT, 32'd10, 1'b0, 1'b0, 1'b0, 1'b0, 8'hFF));
        send_request(make_req(REQ_SAT_COUNT, 32'd20, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
        send_request(make_req(REQ_SAT_COUNT, 32'd30, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        // A tick publishes the pending satellite change; still too early to wake, and
        // findings while asleep are ignored.
        send_request(make_req(REQ_TICK, 32'd1000, 1'b0, 1'b1, 1'b0, 1'b1, 8'd0));
        // Sleep interval passed: wake, run the periodic work and finish at once with
        // both time and location found.
        send_request(make_req(REQ_TICK, 32'd120001, 1'b0, 1'b1, 1'b0, 1'b1, 8'd0));
        // Wake inhibited: a due wake does nothing.
        send_request(make_req(REQ_INHIBIT, 32'd130000, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        send_request(make_req(REQ_TICK, 32'd500000, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        send_request(make_req(REQ_ALLOW_WAKE, 32'd500000, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        // Wake with nothing found; stay awake.
        send_request(make_req(REQ_TICK, 32'd500001, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        // An inhibit does not end a running acquisition.
        send_request(make_req(REQ_INHIBIT, 32'd501000, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        // Location alone is latched but does not end the attempt.
        send_request(make_req(REQ_TICK, 32'd503000, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0));
        // The attempt runs out: position cleared, location dropped, back to sleep.
        send_request(make_req(REQ_TICK, 32'd1500000, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        send_request(make_req(REQ_TICK, 32'd1700000, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        send_request(make_req(REQ_ALLOW_WAKE, 32'd1700000, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        send_request(make_req(REQ_TICK, 32'd1700001, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        // Deep sleep while awake, then again while already asleep.
        send_request(make_req(REQ_DEEP_SLEEP, 32'd1700002, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        send_request(make_req(REQ_DEEP_SLEEP, 32'd1700003, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
        // Top of the time range, then a wrap past zero; the clock already holding
        // GPS time plus a fix ends the attempt.
        send_request(make_req(REQ_TICK, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0));
        send_request(make_req(REQ_TICK, 32'h0000_1000, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0));
        // Unused request codes with every field bit set are ignored.
        send_request(make_req(REQ_SAT_COUNT + 3'd1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1,
                              8'hFF));
        send_request(make_req(REQ_SAT_COUNT + 3'd2, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1,
                              8'hFF));
        send_request(make_req(REQ_SAT_COUNT + 3'd3, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1,
                              8'hFF));
        send_request(make_req(REQ_TICK, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0));
        clock_ms = 32'h7FFF_FFFF;

        // Register settings: short windows, router role, role defaults, forever on
        // either window, both disables, values just either side of 32-bit saturation,
        // the plain defaults, and a final stretch with no idling on either side.
        run_phase(32'd2, 32'd1, 1'b0, 1'b0, 1'b0, 70, 1'b0);
        run_phase(32'd1, 32'd3, 1'b1, 1'b0, 1'b0, 60, 1'b0);
        run_phase('0, '0, 1'b1, 1'b0, 1'b0, 60, 1'b0);
        run_phase('1, 32'd1, 1'b0, 1'b0, 1'b0, 60, 1'b0);
        run_phase(32'd3, '1, 1'b0, 1'b0, 1'b0, 50, 1'b0);
        run_phase(32'd2, 32'd1, 1'b0, 1'b1, 1'b0, 50, 1'b0);
        run_phase(32'd2, 32'd1, 1'b0, 1'b0, 1'b1, 50, 1'b0);
        run_phase(32'd4294968, 32'd4294967, 1'b0, 1'b0, 1'b0, 60, 1'b0);
        run_phase('0, '0, 1'b0, 1'b0, 1'b0, 50, 1'b0);
        run_phase(32'd2, 32'd1, 1'b0, 1'b0, 1'b0, 70, 1'b1);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS gps_duty_cycle_sequencer");
        else
            $display("FAIL gps_duty_cycle_sequencer");
        $finish;
    end

endmodule
